### rtl/ilu_pkg.sv
package ilu_pkg;

   localparam int CELL_CAPACITY = 16384;
   localparam int SHIFT_BITS    = 16;
   localparam int ADDR_BITS     = $clog2(CELL_CAPACITY);
   localparam int CNT_BITS      = ADDR_BITS + 1;
   localparam int KIND_BITS     = 4;
   localparam int DIM_BITS      = 9;
   localparam int PROD_BITS     = 2 * DIM_BITS;
   localparam int RAND_BITS     = 8;
   localparam int CLAIM_BITS    = 4;
   localparam int FIELD_BITS    = 16;
   localparam int CSR_IDX_BITS  = 2;
   localparam int STATE_BITS    = 20;

   localparam logic [CLAIM_BITS-1:0] CLAIM_MAX     = '1;
   localparam logic [KIND_BITS-1:0]  KIND_SOLVENT  = 4'd0;
   localparam logic [KIND_BITS-1:0]  KIND_MEMBRANE = 4'd1;
   localparam logic [KIND_BITS-1:0]  KIND_PORE_K   = 4'd2;
   localparam logic [KIND_BITS-1:0]  KIND_PORE_CL  = 4'd4;
   localparam logic [KIND_BITS-1:0]  KIND_ION_K    = 4'd5;
   localparam logic [KIND_BITS-1:0]  KIND_ION_NA_T = 4'd8;
   localparam logic [KIND_BITS-1:0]  KIND_ION_CL   = 4'd9;
   localparam logic [KIND_BITS-1:0]  KIND_ION_CL_T = 4'd10;

   typedef enum logic [1:0] {
      OP_WRITE_CELL   = 2'd0,
      OP_WRITE_RANDOM = 2'd1,
      OP_READ_CELL    = 2'd2,
      OP_RUN          = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_GRID_WIDTH      = 2'd0,
      CSR_GRID_HEIGHT     = 2'd1,
      CSR_SELECTIVE_PORES = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [DIM_BITS-1:0] width;
      logic [DIM_BITS-1:0] height;
      logic                selective;
   } cfg_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]         kind;
      logic signed [SHIFT_BITS-1:0] sx;
      logic signed [SHIFT_BITS-1:0] sy;
   } cell_type;

   localparam int CELL_BITS = $bits(cell_type);

   typedef struct packed {
      logic                 we;
      logic [ADDR_BITS-1:0] waddr;
      cell_type             wdata;
      logic [ADDR_BITS-1:0] raddr;
   } cell_port_type;

   typedef struct packed {
      logic                 we;
      logic [ADDR_BITS-1:0] waddr;
      logic [RAND_BITS-1:0] wdata;
      logic [ADDR_BITS-1:0] raddr;
   } rand_port_type;

   typedef struct packed {
      logic                  we;
      logic [ADDR_BITS-1:0]  waddr;
      logic [CLAIM_BITS-1:0] wdata;
      logic [ADDR_BITS-1:0]  raddr;
   } claim_port_type;

   function automatic logic is_atom(input logic [KIND_BITS-1:0] k);
      return (k >= KIND_ION_K) && (k <= KIND_ION_CL_T);
   endfunction

   function automatic logic is_pore(input logic [KIND_BITS-1:0] k);
      return (k >= KIND_PORE_K) && (k <= KIND_PORE_CL);
   endfunction

   // Charge change for an ion; toward_right flips the sign of the crossing.
   function automatic logic signed [2:0] charge_delta(input logic [KIND_BITS-1:0] k,
                                                      input logic toward_right);
      logic signed [2:0] q;
      q = 3'sd0;
      if ((k >= KIND_ION_K) && (k <= KIND_ION_NA_T)) q = 3'sd2;
      else if ((k == KIND_ION_CL) || (k == KIND_ION_CL_T)) q = -3'sd2;
      return toward_right ? -q : q;
   endfunction

   function automatic logic passes(input logic [KIND_BITS-1:0] pore,
                                   input logic [KIND_BITS-1:0] ion,
                                   input logic selective);
      logic [KIND_BITS-1:0] species;
      species = (ion - KIND_ION_K) >> 1;
      if (!is_pore(pore) || !is_atom(ion)) return 1'b0;
      if (!selective) return 1'b1;
      return species == (pore - KIND_PORE_K);
   endfunction

   function automatic logic signed [1:0] step_dx(input logic [2:0] d);
      case (d)
         3'd2, 3'd4, 3'd6: return 2'sd1;
         3'd3, 3'd5, 3'd7: return -2'sd1;
         default:          return 2'sd0;
      endcase
   endfunction

   function automatic logic signed [1:0] step_dy(input logic [2:0] d);
      case (d)
         3'd0, 3'd4, 3'd5: return -2'sd1;
         3'd1, 3'd6, 3'd7: return 2'sd1;
         default:          return 2'sd0;
      endcase
   endfunction

   function automatic logic [ADDR_BITS-1:0] neighbor(input logic [ADDR_BITS-1:0] c,
                                                     input logic [2:0] d,
                                                     input logic [DIM_BITS-1:0] w,
                                                     input logic [ADDR_BITS-1:0] mask);
      logic [ADDR_BITS-1:0] wa;
      logic [ADDR_BITS-1:0] t;
      wa = ADDR_BITS'(w);
      t  = c + ADDR_BITS'(step_dx(d));
      if (step_dy(d) == 2'sd1) t = t + wa;
      else if (step_dy(d) == -2'sd1) t = t - wa;
      return t & mask;
   endfunction

   // Index mask of the largest power of two not above min(product, capacity).
   function automatic logic [ADDR_BITS-1:0] grid_mask(input logic [PROD_BITS-1:0] prod);
      logic [CNT_BITS-1:0] lim;
      logic [CNT_BITS-1:0] m;
      lim = (prod < PROD_BITS'(CELL_CAPACITY)) ? CNT_BITS'(prod) : CNT_BITS'(CELL_CAPACITY);
      m = '0;
      for (int i = 0; i < CNT_BITS; i++) begin
         if (lim[i]) m = (CNT_BITS'(1) << i) - CNT_BITS'(1);
      end
      return ADDR_BITS'(m);
   endfunction

   function automatic logic signed [SHIFT_BITS-1:0] to_shift(input logic signed [FIELD_BITS-1:0] v);
      return SHIFT_BITS'(v);
   endfunction

   function automatic logic signed [FIELD_BITS-1:0] from_shift(input logic signed [SHIFT_BITS-1:0] v);
      return FIELD_BITS'(v);
   endfunction

   function automatic logic signed [SHIFT_BITS-1:0] shift_add(input logic signed [SHIFT_BITS-1:0] v,
                                                              input logic signed [2:0] delta);
      return v + SHIFT_BITS'(delta);
   endfunction

   function automatic logic signed [FIELD_BITS-1:0] charge_add(input logic signed [FIELD_BITS-1:0] v,
                                                               input logic signed [2:0] delta);
      logic signed [FIELD_BITS:0] s;
      s = (FIELD_BITS+1)'(v) + (FIELD_BITS+1)'(delta);
      if (s > (FIELD_BITS+1)'(32767)) return 16'sh7fff;
      if (s < -(FIELD_BITS+1)'(32768)) return 16'sh8000;
      return FIELD_BITS'(s);
   endfunction

endpackage

### rtl/ilu_req_if.sv
interface ilu_req_if import ilu_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [1:0]                   operation;
   logic [ADDR_BITS-1:0]         address;
   logic [KIND_BITS-1:0]         cell_kind;
   logic signed [FIELD_BITS-1:0] shift_x_in;
   logic signed [FIELD_BITS-1:0] shift_y_in;
   logic [RAND_BITS-1:0]         random_value;

   modport source (output valid, operation, address, cell_kind, shift_x_in, shift_y_in,
                   random_value, input ready);
   modport sink (input valid, operation, address, cell_kind, shift_x_in, shift_y_in,
                 random_value, output ready);
endinterface

### rtl/ilu_rsp_if.sv
interface ilu_rsp_if import ilu_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [KIND_BITS-1:0]         kind_out;
   logic signed [FIELD_BITS-1:0] shift_x_out;
   logic signed [FIELD_BITS-1:0] shift_y_out;
   logic signed [FIELD_BITS-1:0] charge_balance;

   modport source (output valid, kind_out, shift_x_out, shift_y_out, charge_balance,
                   input ready);
   modport sink (input valid, kind_out, shift_x_out, shift_y_out, charge_balance,
                 output ready);
endinterface

### rtl/ilu_ram.sv
module ilu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

### rtl/ilu_seq.sv
module ilu_seq import ilu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   ilu_req_if.sink               req,
   ilu_rsp_if.source             rsp,
   output cell_port_type         cell_port,
   input  cell_type              cell_rdata,
   output rand_port_type         rand_port,
   input  logic [RAND_BITS-1:0]  rand_rdata,
   output claim_port_type        claim_port,
   input  logic [CLAIM_BITS-1:0] claim_rdata
);
   typedef enum logic [STATE_BITS-1:0] {
      S_IDLE    = STATE_BITS'(1) << 0,
      S_READ    = STATE_BITS'(1) << 1,
      S_RESULT  = STATE_BITS'(1) << 2,
      S_START   = STATE_BITS'(1) << 3,
      S_CLEAR   = STATE_BITS'(1) << 4,
      S_C_RD    = STATE_BITS'(1) << 5,
      S_C_EVAL  = STATE_BITS'(1) << 6,
      S_C_WRC   = STATE_BITS'(1) << 7,
      S_C_RDT   = STATE_BITS'(1) << 8,
      S_C_WRT   = STATE_BITS'(1) << 9,
      S_M_RD    = STATE_BITS'(1) << 10,
      S_M_EVAL  = STATE_BITS'(1) << 11,
      S_M_CHK   = STATE_BITS'(1) << 12,
      S_M_ZERO  = STATE_BITS'(1) << 13,
      S_P_RD    = STATE_BITS'(1) << 14,
      S_P_PORE  = STATE_BITS'(1) << 15,
      S_P_LEFT  = STATE_BITS'(1) << 16,
      S_P_RIGHT = STATE_BITS'(1) << 17,
      S_P_EVAL  = STATE_BITS'(1) << 18,
      S_P_ZERO  = STATE_BITS'(1) << 19
   } state_type;

   state_type                    state_ff, state_in;
   logic [ADDR_BITS-1:0]         c_ff, c_in;
   logic [ADDR_BITS-1:0]         mask_ff, mask_in;
   logic                         atom_ff, atom_in;
   logic [ADDR_BITS-1:0]         tgt_ff, tgt_in;
   cell_type                     mv_ff, mv_in;
   logic [DIM_BITS-1:0]          y_ff, y_in;
   logic [ADDR_BITS-1:0]         row_ff, row_in;
   logic [KIND_BITS-1:0]         pk_ff, pk_in;
   cell_type                     lcell_ff, lcell_in;
   cell_type                     rcell_ff, rcell_in;
   logic [RAND_BITS-1:0]         rr_ff, rr_in;
   logic [ADDR_BITS-1:0]         zaddr_ff, zaddr_in;
   logic signed [FIELD_BITS-1:0] charge_ff, charge_in;
   logic [KIND_BITS-1:0]         res_kind_ff, res_kind_in;
   logic signed [FIELD_BITS-1:0] res_sx_ff, res_sx_in;
   logic signed [FIELD_BITS-1:0] res_sy_ff, res_sy_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [KIND_BITS-1:0]         rsp_kind_ff, rsp_kind_in;
   logic signed [FIELD_BITS-1:0] rsp_sx_ff, rsp_sx_in;
   logic signed [FIELD_BITS-1:0] rsp_sy_ff, rsp_sy_in;
   logic signed [FIELD_BITS-1:0] rsp_charge_ff, rsp_charge_in;

   logic [ADDR_BITS-1:0] half;
   logic [ADDR_BITS-1:0] pore_addr;
   logic [ADDR_BITS-1:0] left_addr;
   logic [ADDR_BITS-1:0] right_addr;
   logic [ADDR_BITS-1:0] req_addr;
   logic [2:0]           dir;
   logic                 last_cell;
   logic                 last_row;

   assign half       = ADDR_BITS'(cfg.width >> 1);
   assign pore_addr  = (row_ff + half) & mask_ff;
   assign left_addr  = (row_ff + half - ADDR_BITS'(1)) & mask_ff;
   assign right_addr = (row_ff + half + ADDR_BITS'(1)) & mask_ff;
   assign req_addr   = ADDR_BITS'(req.address);
   assign dir        = rand_rdata[2:0];
   assign last_cell  = (c_ff == mask_ff);
   assign last_row   = (y_ff == cfg.height - DIM_BITS'(1));

   assign req.ready          = (state_ff == S_IDLE);
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.kind_out       = rsp_kind_ff;
   assign rsp.shift_x_out    = rsp_sx_ff;
   assign rsp.shift_y_out    = rsp_sy_ff;
   assign rsp.charge_balance = rsp_charge_ff;

   always_comb begin
      state_in      = state_ff;
      c_in          = c_ff;
      mask_in       = mask_ff;
      atom_in       = atom_ff;
      tgt_in        = tgt_ff;
      mv_in         = mv_ff;
      y_in          = y_ff;
      row_in        = row_ff;
      pk_in         = pk_ff;
      lcell_in      = lcell_ff;
      rcell_in      = rcell_ff;
      rr_in         = rr_ff;
      zaddr_in      = zaddr_ff;
      charge_in     = charge_ff;
      res_kind_in   = res_kind_ff;
      res_sx_in     = res_sx_ff;
      res_sy_in     = res_sy_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_sx_in     = rsp_sx_ff;
      rsp_sy_in     = rsp_sy_ff;
      rsp_charge_in = rsp_charge_ff;

      cell_port  = '{we: 1'b0, waddr: c_ff, wdata: '0, raddr: c_ff};
      rand_port  = '{we: 1'b0, waddr: req_addr, wdata: req.random_value, raddr: c_ff};
      claim_port = '{we: 1'b0, waddr: c_ff, wdata: '0, raddr: c_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               res_kind_in = '0;
               res_sx_in   = '0;
               res_sy_in   = '0;
               state_in    = S_RESULT;
               case (op_type'(req.operation))
                  OP_WRITE_CELL: begin
                     cell_port.we    = 1'b1;
                     cell_port.waddr = req_addr;
                     cell_port.wdata = '{kind: req.cell_kind, sx: to_shift(req.shift_x_in),
                                         sy: to_shift(req.shift_y_in)};
                  end
                  OP_WRITE_RANDOM: rand_port.we = 1'b1;
                  OP_READ_CELL: begin
                     cell_port.raddr = req_addr;
                     state_in        = S_READ;
                  end
                  default: state_in = S_START;
               endcase
            end
         end
         S_READ: begin
            res_kind_in = cell_rdata.kind;
            res_sx_in   = from_shift(cell_rdata.sx);
            res_sy_in   = from_shift(cell_rdata.sy);
            state_in    = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = res_kind_ff;
               rsp_sx_in     = res_sx_ff;
               rsp_sy_in     = res_sy_ff;
               rsp_charge_in = charge_ff;
               state_in      = S_IDLE;
            end
         end
         S_START: begin
            c_in = '0;
            if (cfg.width == '0 || cfg.height == '0) begin
               state_in = S_RESULT;
            end else begin
               mask_in  = grid_mask(PROD_BITS'(cfg.width) * PROD_BITS'(cfg.height));
               state_in = S_CLEAR;
            end
         end
         S_CLEAR: begin
            claim_port.we = 1'b1;
            if (last_cell) begin
               c_in     = '0;
               state_in = S_C_RD;
            end else begin
               c_in = c_ff + ADDR_BITS'(1);
            end
         end
         S_C_RD: state_in = S_C_EVAL;
         S_C_EVAL: begin
            atom_in = is_atom(cell_rdata.kind);
            tgt_in  = neighbor(c_ff, dir, cfg.width, mask_ff);
            if (is_atom(cell_rdata.kind) || is_pore(cell_rdata.kind) ||
                cell_rdata.kind == KIND_MEMBRANE) begin
               state_in = S_C_WRC;
            end else if (last_cell) begin
               c_in     = '0;
               state_in = S_M_RD;
            end else begin
               c_in     = c_ff + ADDR_BITS'(1);
               state_in = S_C_RD;
            end
         end
         S_C_WRC: begin
            claim_port.we    = 1'b1;
            claim_port.wdata = (claim_rdata == CLAIM_MAX) ? CLAIM_MAX
                               : claim_rdata + CLAIM_BITS'(1);
            if (atom_ff) begin
               state_in = S_C_RDT;
            end else if (last_cell) begin
               c_in     = '0;
               state_in = S_M_RD;
            end else begin
               c_in     = c_ff + ADDR_BITS'(1);
               state_in = S_C_RD;
            end
         end
         S_C_RDT: begin
            claim_port.raddr = tgt_ff;
            state_in         = S_C_WRT;
         end
         S_C_WRT: begin
            claim_port.we    = 1'b1;
            claim_port.waddr = tgt_ff;
            claim_port.wdata = (claim_rdata == CLAIM_MAX) ? CLAIM_MAX
                               : claim_rdata + CLAIM_BITS'(1);
            if (last_cell) begin
               c_in     = '0;
               state_in = S_M_RD;
            end else begin
               c_in     = c_ff + ADDR_BITS'(1);
               state_in = S_C_RD;
            end
         end
         S_M_RD: state_in = S_M_EVAL;
         S_M_EVAL: begin
            tgt_in = neighbor(c_ff, dir, cfg.width, mask_ff);
            mv_in  = '{kind: cell_rdata.kind,
                       sx: shift_add(cell_rdata.sx, 3'(step_dx(dir))),
                       sy: shift_add(cell_rdata.sy, 3'(step_dy(dir)))};
            if (claim_rdata == CLAIM_BITS'(1) && is_atom(cell_rdata.kind)) begin
               claim_port.raddr = neighbor(c_ff, dir, cfg.width, mask_ff);
               state_in         = S_M_CHK;
            end else if (last_cell) begin
               y_in     = '0;
               row_in   = '0;
               state_in = S_P_RD;
            end else begin
               c_in     = c_ff + ADDR_BITS'(1);
               state_in = S_M_RD;
            end
         end
         S_M_CHK: begin
            if (claim_rdata == CLAIM_BITS'(1)) begin
               claim_port.we    = 1'b1;
               claim_port.waddr = tgt_ff;
               cell_port.we     = 1'b1;
               cell_port.waddr  = tgt_ff;
               cell_port.wdata  = mv_ff;
               state_in         = S_M_ZERO;
            end else if (last_cell) begin
               y_in     = '0;
               row_in   = '0;
               state_in = S_P_RD;
            end else begin
               c_in     = c_ff + ADDR_BITS'(1);
               state_in = S_M_RD;
            end
         end
         S_M_ZERO: begin
            // The source is cleared after the destination so a self move ends empty.
            cell_port.we = 1'b1;
            if (last_cell) begin
               y_in     = '0;
               row_in   = '0;
               state_in = S_P_RD;
            end else begin
               c_in     = c_ff + ADDR_BITS'(1);
               state_in = S_M_RD;
            end
         end
         S_P_RD: begin
            cell_port.raddr = pore_addr;
            state_in        = S_P_PORE;
         end
         S_P_PORE: begin
            pk_in = cell_rdata.kind;
            if (is_pore(cell_rdata.kind)) begin
               cell_port.raddr = left_addr;
               state_in        = S_P_LEFT;
            end else if (last_row) begin
               state_in = S_RESULT;
            end else begin
               y_in     = y_ff + DIM_BITS'(1);
               row_in   = row_ff + ADDR_BITS'(cfg.width);
               state_in = S_P_RD;
            end
         end
         S_P_LEFT: begin
            lcell_in        = cell_rdata;
            cell_port.raddr = right_addr;
            rand_port.raddr = right_addr;
            state_in        = S_P_RIGHT;
         end
         S_P_RIGHT: begin
            rcell_in        = cell_rdata;
            rr_in           = rand_rdata;
            rand_port.raddr = left_addr;
            state_in        = S_P_EVAL;
         end
         S_P_EVAL: begin
            if (is_atom(lcell_ff.kind) && rcell_ff.kind == KIND_SOLVENT &&
                passes(pk_ff, lcell_ff.kind, cfg.selective) && !rr_ff[RAND_BITS-1]) begin
               cell_port.we    = 1'b1;
               cell_port.waddr = right_addr;
               cell_port.wdata = '{kind: lcell_ff.kind, sx: shift_add(lcell_ff.sx, 3'sd2),
                                   sy: lcell_ff.sy};
               charge_in       = charge_add(charge_ff, charge_delta(lcell_ff.kind, 1'b1));
               zaddr_in        = left_addr;
               state_in        = S_P_ZERO;
            end else if (is_atom(rcell_ff.kind) && lcell_ff.kind == KIND_SOLVENT &&
                         passes(pk_ff, rcell_ff.kind, cfg.selective) &&
                         !rand_rdata[RAND_BITS-1]) begin
               cell_port.we    = 1'b1;
               cell_port.waddr = left_addr;
               cell_port.wdata = '{kind: rcell_ff.kind, sx: shift_add(rcell_ff.sx, -3'sd2),
                                   sy: rcell_ff.sy};
               charge_in       = charge_add(charge_ff, charge_delta(rcell_ff.kind, 1'b0));
               zaddr_in        = right_addr;
               state_in        = S_P_ZERO;
            end else if (last_row) begin
               state_in = S_RESULT;
            end else begin
               y_in     = y_ff + DIM_BITS'(1);
               row_in   = row_ff + ADDR_BITS'(cfg.width);
               state_in = S_P_RD;
            end
         end
         S_P_ZERO: begin
            cell_port.we    = 1'b1;
            cell_port.waddr = zaddr_ff;
            if (last_row) begin
               state_in = S_RESULT;
            end else begin
               y_in     = y_ff + DIM_BITS'(1);
               row_in   = row_ff + ADDR_BITS'(cfg.width);
               state_in = S_P_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         charge_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         charge_ff    <= charge_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      c_ff          <= c_in;
      mask_ff       <= mask_in;
      atom_ff       <= atom_in;
      tgt_ff        <= tgt_in;
      mv_ff         <= mv_in;
      y_ff          <= y_in;
      row_ff        <= row_in;
      pk_ff         <= pk_in;
      lcell_ff      <= lcell_in;
      rcell_ff      <= rcell_in;
      rr_ff         <= rr_in;
      zaddr_ff      <= zaddr_in;
      res_kind_ff   <= res_kind_in;
      res_sx_ff     <= res_sx_in;
      res_sy_ff     <= res_sy_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_sx_ff     <= rsp_sx_in;
      rsp_sy_ff     <= rsp_sy_in;
      rsp_charge_ff <= rsp_charge_in;
   end
endmodule

### rtl/ion_lattice_update_engine.sv
// Cell and random writes go through S_RESULT to the output register; reads pass S_READ
// first. A run clears the claim memory, then makes a claim pass and a move pass over the
// grid cells and a pore pass over its rows, through the single read and write port of each memory.
// One operation is in work at a time; a finished word waits in the output register.
// Reset (synchronous) clears control, the charge balance and the configuration to
// 64 by 64 with selective pores; cell memories hold nothing until written.
module ion_lattice_update_engine import ilu_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   ilu_req_if.sink                 req_chan,
   ilu_rsp_if.source               rsp_chan,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [DIM_BITS-1:0]     csr_wr_data
);
   cfg_type               cfg_ff, cfg_in;
   cell_port_type         cell_port;
   rand_port_type         rand_port;
   claim_port_type        claim_port;
   logic [CELL_BITS-1:0]  cell_rdata;
   logic [RAND_BITS-1:0]  rand_rdata;
   logic [CLAIM_BITS-1:0] claim_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRID_WIDTH:      cfg_in.width     = csr_wr_data;
            CSR_GRID_HEIGHT:     cfg_in.height    = csr_wr_data;
            CSR_SELECTIVE_PORES: cfg_in.selective = csr_wr_data[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{width: DIM_BITS'(64), height: DIM_BITS'(64), selective: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ilu_ram #(.WIDTH(CELL_BITS), .DEPTH(CELL_CAPACITY)) u_cell_ram (
      .clock (clock),
      .we    (cell_port.we),
      .waddr (cell_port.waddr),
      .wdata (cell_port.wdata),
      .raddr (cell_port.raddr),
      .rdata (cell_rdata)
   );

   ilu_ram #(.WIDTH(RAND_BITS), .DEPTH(CELL_CAPACITY)) u_rand_ram (
      .clock (clock),
      .we    (rand_port.we),
      .waddr (rand_port.waddr),
      .wdata (rand_port.wdata),
      .raddr (rand_port.raddr),
      .rdata (rand_rdata)
   );

   ilu_ram #(.WIDTH(CLAIM_BITS), .DEPTH(CELL_CAPACITY)) u_claim_ram (
      .clock (clock),
      .we    (claim_port.we),
      .waddr (claim_port.waddr),
      .wdata (claim_port.wdata),
      .raddr (claim_port.raddr),
      .rdata (claim_rdata)
   );

   ilu_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .cell_port   (cell_port),
      .cell_rdata  (cell_type'(cell_rdata)),
      .rand_port   (rand_port),
      .rand_rdata  (rand_rdata),
      .claim_port  (claim_port),
      .claim_rdata (claim_rdata)
   );
endmodule

### rtl/ilu_checker.sv
module ilu_checker import ilu_pkg::*; (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [1:0]                   req_operation,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [KIND_BITS-1:0]         rsp_kind,
   input logic signed [FIELD_BITS-1:0] rsp_sx,
   input logic signed [FIELD_BITS-1:0] rsp_sy
);
   logic       push;
   logic       pop;
   logic [1:0] cnt_ff;
   logic [1:0] pos;
   op_type     op0_ff;
   op_type     op1_ff;

   assign push = req_valid && req_ready;
   assign pop  = rsp_valid && rsp_ready;
   assign pos  = cnt_ff - 2'(pop);

   // Operations still owed a word, oldest first.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (pop) op0_ff <= op1_ff;
      if (push) begin
         if (pos == 2'd0) op0_ff <= op_type'(req_operation);
         else op1_ff <= op_type'(req_operation);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != 2'd0)
      else $error("response word without an accepted request");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      push |-> cnt_ff < 2'd2)
      else $error("request accepted while another is still in work");

   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && cnt_ff != 2'd0 && op0_ff != OP_READ_CELL
      |-> rsp_kind == '0 && rsp_sx == '0 && rsp_sy == '0)
      else $error("cell fields not zero for an operation other than a read");
endmodule

bind ion_lattice_update_engine ilu_checker u_ilu_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_operation (req_chan.operation),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_kind      (rsp_chan.kind_out),
   .rsp_sx        (rsp_chan.shift_x_out),
   .rsp_sy        (rsp_chan.shift_y_out)
);

### dv/tb.sv
`timescale 1ns / 100ps

module tb import ilu_pkg::*; ();

   localparam int LIMIT_CYCLES = 4000000;

   typedef struct {
      op_type                       op;
      logic [ADDR_BITS-1:0]         addr;
      logic [KIND_BITS-1:0]         kind;
      logic signed [FIELD_BITS-1:0] sx;
      logic signed [FIELD_BITS-1:0] sy;
      logic [RAND_BITS-1:0]         rnd;
   } lattice_op_t;

   typedef struct {
      logic [KIND_BITS-1:0]         kind;
      logic signed [FIELD_BITS-1:0] sx;
      logic signed [FIELD_BITS-1:0] sy;
      logic signed [FIELD_BITS-1:0] charge;
   } lattice_word_t;

   logic                    clock;
   logic                    reset;
   logic                    csr_wr_en;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [DIM_BITS-1:0]     csr_wr_data;

   ilu_req_if req_chan ();
   ilu_rsp_if rsp_chan ();

   ion_lattice_update_engine u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the lattice.
   logic [KIND_BITS-1:0]  kind_m  [CELL_CAPACITY];
   logic [15:0]           sx_m    [CELL_CAPACITY];
   logic [15:0]           sy_m    [CELL_CAPACITY];
   logic [RAND_BITS-1:0]  rnd_m   [CELL_CAPACITY];
   bit                    written [CELL_CAPACITY];
   int unsigned           width_m, height_m;
   bit                    selective_m;
   int                    charge_m;

   lattice_op_t   pending_ops[$];
   lattice_word_t expected_words[$];
   lattice_op_t   cur_op;
   bit            req_took;
   int            gap_left;
   int            stall_left;
   int            idle_pct;
   int            errors;
   int            cycles;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic bit atom_kind(logic [KIND_BITS-1:0] k);
      return k >= KIND_ION_K && k <= KIND_ION_CL_T;
   endfunction

   function automatic bit pore_kind(logic [KIND_BITS-1:0] k);
      return k >= KIND_PORE_K && k <= KIND_PORE_CL;
   endfunction

   function automatic bit pore_admits(logic [KIND_BITS-1:0] pk, logic [KIND_BITS-1:0] ion);
      if (!pore_kind(pk) || !atom_kind(ion)) return 0;
      if (!selective_m) return 1;
      return ((ion - KIND_ION_K) >> 1) == (pk - KIND_PORE_K);
   endfunction

   function automatic int unsigned grid_cells(int unsigned w, int unsigned h);
      int unsigned lim;
      int unsigned size;
      lim = (w * h < CELL_CAPACITY) ? w * h : CELL_CAPACITY;
      size = 1;
      if (lim == 0) return 0;
      while (size * 2 <= lim) size = size * 2;
      return size;
   endfunction

   function automatic void shift_cell(int unsigned from, int unsigned to, int dx, int dy);
      sx_m[to]    = sx_m[from] + 16'(dx);
      sy_m[to]    = sy_m[from] + 16'(dy);
      kind_m[to]  = kind_m[from];
      sx_m[from]  = '0;
      sy_m[from]  = '0;
      kind_m[from] = KIND_SOLVENT;
   endfunction

   function automatic void bump_charge(int d);
      charge_m = charge_m + d;
      if (charge_m > 32767) charge_m = 32767;
      if (charge_m < -32768) charge_m = -32768;
   endfunction

   function automatic int ion_sign(logic [KIND_BITS-1:0] k);
      if (k >= KIND_ION_K && k <= KIND_ION_NA_T) return 1;
      if (k == KIND_ION_CL || k == KIND_ION_CL_T) return -1;
      return 0;
   endfunction

   // One iteration: claim pass, move pass in address order, then the pore column.
   function automatic void run_lattice();
      int          dxs[8] = '{0, 0, 1, -1, 1, -1, 1, -1};
      int          dys[8] = '{-1, 1, 0, 0, -1, -1, 1, 1};
      int unsigned off[8];
      int unsigned w, h, size, mask, half, to, d, row, pore, lft, rgt;
      logic [3:0]  claims[];
      w = width_m;
      h = height_m;
      size = grid_cells(w, h);
      if (size == 0) return;
      mask = size - 1;
      half = w / 2;
      off[0] = 0 - w; off[1] = w;         off[2] = 1;     off[3] = 0 - 1;
      off[4] = 1 - w; off[5] = 0 - w - 1; off[6] = w + 1; off[7] = w - 1;
      claims = new[size];
      foreach (claims[i]) claims[i] = '0;
      for (int unsigned c = 0; c < size; c++) begin
         if (atom_kind(kind_m[c])) begin
            if (claims[c] != 4'hf) claims[c]++;
            to = (c + off[rnd_m[c][2:0]]) & mask;
            if (claims[to] != 4'hf) claims[to]++;
         end
         if (kind_m[c] == KIND_MEMBRANE || pore_kind(kind_m[c])) begin
            if (claims[c] != 4'hf) claims[c]++;
         end
      end
      for (int unsigned c = 0; c < size; c++) begin
         if (claims[c] == 4'd1 && atom_kind(kind_m[c])) begin
            d  = rnd_m[c][2:0];
            to = (c + off[d]) & mask;
            if (claims[to] == 4'd1) begin
               shift_cell(c, to, dxs[d], dys[d]);
               claims[to] = '0;
            end
         end
      end
      for (int unsigned y = 0; y < h; y++) begin
         row  = y * w;
         pore = (row + half) & mask;
         lft  = (row + half - 1) & mask;
         rgt  = (row + half + 1) & mask;
         if (pore_kind(kind_m[pore])) begin
            if (atom_kind(kind_m[lft]) && kind_m[rgt] == KIND_SOLVENT &&
                pore_admits(kind_m[pore], kind_m[lft]) && rnd_m[rgt] <= 8'd127) begin
               bump_charge(-2 * ion_sign(kind_m[lft]));
               shift_cell(lft, rgt, 2, 0);
            end else if (atom_kind(kind_m[rgt]) && kind_m[lft] == KIND_SOLVENT &&
                         pore_admits(kind_m[pore], kind_m[rgt]) && rnd_m[lft] <= 8'd127) begin
               bump_charge(2 * ion_sign(kind_m[rgt]));
               shift_cell(rgt, lft, -2, 0);
            end
         end
      end
   endfunction

   function automatic lattice_word_t predict_op(lattice_op_t t);
      lattice_word_t w;
      w.kind = '0;
      w.sx   = '0;
      w.sy   = '0;
      case (t.op)
         OP_WRITE_CELL: begin
            kind_m[t.addr] = t.kind;
            sx_m[t.addr]   = t.sx;
            sy_m[t.addr]   = t.sy;
         end
         OP_WRITE_RANDOM: rnd_m[t.addr] = t.rnd;
         OP_READ_CELL: begin
            w.kind = kind_m[t.addr];
            w.sx   = sx_m[t.addr];
            w.sy   = sy_m[t.addr];
         end
         default: run_lattice();
      endcase
      w.charge = 16'(charge_m);
      return w;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
      errors++;
   endtask

   function automatic int draw_gap();
      if ($urandom_range(99) >= idle_pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(40, 10);
      return $urandom_range(3, 1);
   endfunction

   // Request side: a word stays up until it is taken.
   always @(posedge clock) begin
      req_took = !reset && req_chan.valid && req_chan.ready;
      if (req_took) expected_words.push_back(predict_op(cur_op));
   end

   always @(negedge clock) begin
      if (!reset && !(req_chan.valid && !req_took)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            cur_op = pending_ops.pop_front();
            req_chan.operation    <= cur_op.op;
            req_chan.address      <= cur_op.addr;
            req_chan.cell_kind    <= cur_op.kind;
            req_chan.shift_x_in   <= cur_op.sx;
            req_chan.shift_y_in   <= cur_op.sy;
            req_chan.random_value <= cur_op.rnd;
            req_chan.valid        <= 1'b1;
            gap_left = draw_gap();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Result side.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         stall_left = draw_gap();
      end
   end

   always @(posedge clock) begin
      lattice_word_t w;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_words.size() == 0) begin
            $display("unexpected word at cycle %0d", cycles);
            errors++;
         end else begin
            w = expected_words.pop_front();
            if (rsp_chan.kind_out !== w.kind)
               report_mismatch("kind_out", rsp_chan.kind_out, w.kind);
            if (rsp_chan.shift_x_out !== w.sx)
               report_mismatch("shift_x_out", rsp_chan.shift_x_out, w.sx);
            if (rsp_chan.shift_y_out !== w.sy)
               report_mismatch("shift_y_out", rsp_chan.shift_y_out, w.sy);
            if (rsp_chan.charge_balance !== w.charge)
               report_mismatch("charge_balance", rsp_chan.charge_balance, w.charge);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("** ion_lattice_update_engine: FAILED **");
         $finish;
      end
   end

   task automatic push_op(op_type op, int unsigned addr, logic [3:0] kind,
                          logic [15:0] sx, logic [15:0] sy, logic [7:0] rnd);
      lattice_op_t t;
      t.op   = op;
      t.addr = ADDR_BITS'(addr);
      t.kind = kind;
      t.sx   = sx;
      t.sy   = sy;
      t.rnd  = rnd;
      if (op == OP_WRITE_CELL) written[addr] = 1;
      pending_ops.push_back(t);
   endtask

   task automatic write_csr(csr_index_type idx, int unsigned value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= DIM_BITS'(value);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic configure(int unsigned w, int unsigned h, bit sel);
      write_csr(CSR_GRID_WIDTH, w);
      write_csr(CSR_GRID_HEIGHT, h);
      write_csr(CSR_SELECTIVE_PORES, sel);
      width_m     = w;
      height_m    = h;
      selective_m = sel;
   endtask

   function automatic logic [3:0] pick_kind(int unsigned x, int unsigned w);
      int unsigned r;
      r = $urandom_range(99);
      if (x == w / 2) begin
         return (r < 60) ? 4'($urandom_range(KIND_PORE_CL, KIND_PORE_K)) : KIND_MEMBRANE;
      end
      if (r < 45) return KIND_SOLVENT;
      if (r < 85) return 4'($urandom_range(KIND_ION_CL_T, KIND_ION_K));
      if (r < 93) return 4'($urandom_range(15, 11));
      return 4'($urandom_range(15));
   endfunction

   // Every cell and random byte of the grid is written before any run reads it.
   // Cells kept from an earlier phase are already valid and are not sent again.
   task automatic fill_grid();
      int unsigned size;
      size = grid_cells(width_m, height_m);
      for (int unsigned c = 0; c < size; c++) begin
         if (!written[c]) begin
            push_op(OP_WRITE_CELL, c, pick_kind(c % width_m, width_m),
                    16'($urandom), 16'($urandom), '0);
            push_op(OP_WRITE_RANDOM, c, '0, '0, '0, 8'($urandom));
         end
      end
   endtask

   task automatic random_ops(int n);
      int unsigned size, a, r;
      size = grid_cells(width_m, height_m);
      for (int i = 0; i < n; i++) begin
         a = $urandom_range(size - 1);
         r = $urandom_range(99);
         if (r < 25)
            push_op(OP_WRITE_CELL, a, pick_kind(a % width_m, width_m),
                    16'($urandom), 16'($urandom), 8'($urandom));
         else if (r < 50)
            push_op(OP_WRITE_RANDOM, a, 4'($urandom), 16'($urandom), 16'($urandom),
                    8'($urandom));
         else if (r < 80)
            push_op(OP_READ_CELL, a, 4'($urandom), 16'($urandom), 16'($urandom),
                    8'($urandom));
         else
            push_op(OP_RUN, $urandom_range(16383), 4'($urandom), '0, '0, '0);
      end
      push_op(OP_RUN, 0, '0, '0, '0, '0);
      for (int i = 0; i < 6; i++)
         push_op(OP_READ_CELL, $urandom_range(size - 1), '0, '0, '0, '0);
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pending_ops.size() > 0 || req_chan.valid || expected_words.size() > 0);
      repeat (10) @(negedge clock);
   endtask

   task automatic run_phase(int unsigned w, int unsigned h, bit sel, int n);
      configure(w, h, sel);
      idle_pct = $urandom_range(3) == 0 ? 0 : $urandom_range(60, 20);
      fill_grid();
      random_ops(n);
      drain();
   endtask

   initial begin
      errors      = 0;
      cycles      = 0;
      gap_left    = 0;
      stall_left  = 0;
      idle_pct    = 30;
      req_took    = 0;
      charge_m    = 0;
      width_m     = 64;
      height_m    = 64;
      selective_m = 1;
      foreach (kind_m[i]) begin
         kind_m[i]  = '0;
         sx_m[i]    = '0;
         sy_m[i]    = '0;
         rnd_m[i]   = '0;
         written[i] = 0;
      end
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_index             = CSR_GRID_WIDTH;
      csr_wr_data           = '0;
      req_chan.valid        = 1'b0;
      req_chan.operation    = OP_WRITE_CELL;
      req_chan.address      = '0;
      req_chan.cell_kind    = '0;
      req_chan.shift_x_in   = '0;
      req_chan.shift_y_in   = '0;
      req_chan.random_value = '0;
      rsp_chan.ready        = 1'b0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Directed: smallest grid, field extremes at the top of the address space.
      configure(8, 2, 0);
      fill_grid();
      push_op(OP_WRITE_CELL, 16383, 4'd15, 16'h7fff, 16'h8000, '0);
      push_op(OP_WRITE_CELL, 8192, 4'd11, 16'h8000, 16'h7fff, '0);
      push_op(OP_WRITE_RANDOM, 16383, '0, '0, '0, 8'hff);
      push_op(OP_WRITE_RANDOM, 8192, '0, '0, '0, 8'h00);
      push_op(OP_READ_CELL, 16383, '0, '0, '0, '0);
      push_op(OP_READ_CELL, 8192, '0, '0, '0, '0);
      push_op(OP_WRITE_CELL, 3, KIND_ION_CL_T, 16'hffff, 16'h0001, '0);
      push_op(OP_WRITE_CELL, 5, KIND_ION_K, 16'h7fff, 16'h8000, '0);
      push_op(OP_WRITE_CELL, 4, KIND_PORE_K, '0, '0, '0);
      push_op(OP_WRITE_RANDOM, 5, '0, '0, '0, 8'd2);
      push_op(OP_RUN, 0, '0, '0, '0, '0);
      for (int c = 0; c < 8; c++) push_op(OP_READ_CELL, c, '0, '0, '0, '0);
      push_op(OP_READ_CELL, 16383, '0, '0, '0, '0);
      drain();

      // Grids whose cell count rounds down to the same sixteen cells.
      run_phase(8, 2, 1, 10);
      run_phase(9, 3, 0, 10);
      run_phase(12, 2, 1, 10);

      if (errors == 0) begin
         $display("** ion_lattice_update_engine: PASSED **");
      end else begin
         $display("** ion_lattice_update_engine: FAILED **");
      end
      $finish;
   end

endmodule
